FILE: hdl/ica_pkg.sv
// shared constants and the arctangent table for the imu attitude filter
package ica_pkg;

    localparam int AngleBitsDef  = 24;
    localparam int SampleBitsDef = 16;

    // accel samples are normalized to this width before the angle math
    localparam int AccW        = 24;
    localparam int CordicW     = 44;
    localparam int CordicSteps = 28;
    localparam int SqrtSteps   = 31;
    localparam int BlendSteps  = 17;
    localparam int GainW       = 16;
    localparam int CfgW        = 32;

    localparam logic [31:0] HalfTurn = 32'h8000_0000;

    localparam logic [1:0] RegAlpha    = 2'd0;
    localparam logic [1:0] RegGyro     = 2'd1;
    localparam logic [1:0] RegDeadband = 2'd2;

    localparam logic [15:0] AlphaReset    = 16'd64225;
    localparam logic [15:0] GyroReset     = 16'd911;
    localparam logic [31:0] DeadbandReset = 32'd17161;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] AtanTurn [CordicSteps] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5
    };

endpackage

FILE: hdl/imu_complementary_attitude_filter.sv
// complementary roll, pitch and yaw filter over one raw imu sample per word
//
// input channel s_*: one word per sample, six signed axes in s_tdata and the
// mode bit in s_tuser (1 clears all three angles). result channel m_*: one word
// per input word with roll, pitch, yaw and the yaw_moved flag.
// configuration: cfg_we writes cfg_wdata to register cfg_index (0 alpha_gain,
// 1 gyro_gain, 2 deadband_sq); other indexes are ignored.
// a sample runs from acceptance to the result register in these steps: the roll
// cordic run alongside the bit-serial squares and gyro products, the square root
// digit loop with the roll blend, the pitch cordic, the bit-serial pitch blend and
// the load of the result; a clear word goes from acceptance straight to that load.
// s_tready is high only while the datapath is free, from the load of the result
// register on, so a new word is taken only after the last one has reached it; a
// new word may enter while the result waits.
// a stalled receiver holds the result register; a finished sample waits for it.
// reset (synchronous, aresetn low) zeroes all angles and restores the registers.
module imu_complementary_attitude_filter #(
    parameter int ANGLE_BITS  = ica_pkg::AngleBitsDef,
    parameter int SAMPLE_BITS = ica_pkg::SampleBitsDef
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // mode
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // roll_angle, pitch_angle, yaw_angle, yaw_moved
    output logic [((3*ANGLE_BITS+1+7)/8)*8-1:0] m_tdata,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [ica_pkg::CfgW-1:0] cfg_wdata
);

    localparam int SW    = SAMPLE_BITS;
    localparam int AW    = ANGLE_BITS;
    localparam int AC    = ica_pkg::AccW;
    localparam int CW    = ica_pkg::CordicW;
    localparam int GW    = ica_pkg::GainW;
    localparam int PW    = SW + GW + 1;
    localparam int SQW   = 2 * SW;
    localparam int AQW   = 2 * AC;
    localparam int VW    = 62;
    localparam int RW    = 31;
    localparam int REMW  = 35;
    localparam int BW    = AW + 18;
    localparam int SH    = 32 - AW;
    localparam int MAGW  = SQW + 2;
    localparam int CMPW  = (MAGW > ica_pkg::CfgW) ? MAGW : ica_pkg::CfgW;
    localparam int OUTW  = ((3*AW+1+7)/8)*8;
    localparam logic [32:0] Rnd = (33'd1 << SH) >> 1;
    localparam logic [4:0] CordicLast = 5'(ica_pkg::CordicSteps);
    localparam logic [4:0] SqrtLast   = 5'(ica_pkg::SqrtSteps);
    localparam logic [4:0] BlendLast  = 5'(ica_pkg::BlendSteps);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SQRT, S_PITCH, S_PBLEND, S_OUT
    } state_t;

    state_t state_reg;
    logic [4:0] cnt_reg;

    logic [15:0] alpha_reg;
    logic [15:0] gain_reg;
    logic [31:0] deadband_reg;

    logic [AW-1:0] roll_reg, pitch_reg, yaw_reg, pred_reg;
    logic moved_reg;
    logic signed [AC-1:0] nx_reg;

    logic [AQW-1:0] asq_a_reg [2];
    logic [AC-1:0]  asq_b_reg [2];
    logic [AQW-1:0] asq_p_reg [2];
    logic [SQW-1:0] gsq_a_reg [3];
    logic [SW-1:0]  gsq_b_reg [3];
    logic [SQW-1:0] gsq_p_reg [3];
    logic signed [PW-1:0] gg_a_reg [3];
    logic [GW-1:0]        gg_b_reg [3];
    logic signed [PW-1:0] gg_p_reg [3];

    logic signed [CW-1:0] cx_reg, cy_reg;
    logic [31:0] cz_reg;
    logic czero_reg;

    logic [VW-1:0] sq_v_reg;
    logic [REMW-3:0] sq_rem_reg;
    logic [RW-1:0] sq_r_reg;

    logic signed [BW-1:0] bm_a_reg, bm_p_reg;
    logic [16:0] bm_b_reg;

    logic m_tvalid_reg;
    logic [OUTW-1:0] m_tdata_reg;

    // input unpacking
    logic signed [SW-1:0] in_a [3];
    logic signed [SW-1:0] in_g [3];
    logic signed [AC-1:0] in_n [3];
    logic [AC-1:0] in_nabs [3];
    logic [SW-1:0] in_gabs [3];
    logic accept;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_a[k] = $signed(s_tdata[k*SW +: SW]);
            in_g[k] = $signed(s_tdata[(k+3)*SW +: SW]);
            in_n[k] = AC'(in_a[k]) <<< (AC - SW);
            in_nabs[k] = in_n[k][AC-1] ? (~in_n[k] + 1'b1) : in_n[k];
            in_gabs[k] = in_g[k][SW-1] ? (~in_g[k] + 1'b1) : in_g[k];
        end
    end

    assign accept = s_tvalid && s_tready;

    // gyro steps in angle units
    logic signed [PW-1:0] gg_rnd [3];
    logic signed [PW-1:0] gg_sh [3];
    logic [AW-1:0] delta [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            gg_rnd[k] = gg_p_reg[k] + PW'(128);
            gg_sh[k]  = gg_rnd[k] >>> 8;
            delta[k]  = AW'(gg_sh[k]);
        end
    end

    // cordic load, step and rounding
    logic signed [CW-1:0] ld_y, ld_x, cxs, cys;
    logic ld_neg;
    logic [32:0] z_sum;
    logic [AW-1:0] c_angle;
    logic [31:0] at_step;

    always_comb begin
        if (state_reg == S_SQRT) begin
            ld_y = -(CW'(nx_reg) <<< 15);
            ld_x = CW'($signed({1'b0, sq_r_reg})) <<< 8;
        end else begin
            ld_y = CW'(in_n[1]) <<< 8;
            ld_x = CW'(in_n[2]) <<< 8;
        end
        ld_neg  = ld_x[CW-1];
        cxs     = cx_reg >>> cnt_reg;
        cys     = cy_reg >>> cnt_reg;
        at_step = ica_pkg::AtanTurn[cnt_reg];
        z_sum   = {1'b0, cz_reg} + Rnd;
        c_angle = z_sum[31:SH];
    end

    // square root digit step
    logic [REMW-1:0] rem_sh, trial;
    logic ge;
    logic [AQW:0] asq_sum;

    always_comb begin
        rem_sh  = {sq_rem_reg, sq_v_reg[VW-1:VW-2]};
        trial   = {2'b00, sq_r_reg, 2'b01};
        ge      = rem_sh >= trial;
        asq_sum = {1'b0, asq_p_reg[0]} + {1'b0, asq_p_reg[1]};
    end

    // blend correction and deadband test
    logic signed [BW-1:0] bm_rnd;
    logic [AW-1:0] corr, diff;
    logic [MAGW-1:0] mag;
    logic above;

    always_comb begin
        bm_rnd = bm_p_reg + BW'(32768);
        corr   = bm_rnd[AW+15:16];
        diff   = c_angle - pred_reg;
        mag    = MAGW'(gsq_p_reg[0]) + MAGW'(gsq_p_reg[1]) + MAGW'(gsq_p_reg[2]);
        above  = CMPW'(mag) > CMPW'(deadband_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg    <= ica_pkg::AlphaReset;
            gain_reg     <= ica_pkg::GyroReset;
            deadband_reg <= ica_pkg::DeadbandReset;
        end else if (cfg_we) begin
            case (cfg_index)
                ica_pkg::RegAlpha:    alpha_reg    <= cfg_wdata[15:0];
                ica_pkg::RegGyro:     gain_reg     <= cfg_wdata[15:0];
                ica_pkg::RegDeadband: deadband_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            roll_reg     <= '0;
            pitch_reg    <= '0;
            yaw_reg      <= '0;
            moved_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    cnt_reg <= '0;
                    if (accept && s_tuser) begin
                        roll_reg  <= '0;
                        pitch_reg <= '0;
                        yaw_reg   <= '0;
                        moved_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end else if (accept) begin
                        nx_reg <= in_n[0];
                        for (int k = 0; k < 2; k++) begin
                            asq_a_reg[k] <= AQW'(in_nabs[k+1]);
                            asq_b_reg[k] <= in_nabs[k+1];
                            asq_p_reg[k] <= '0;
                        end
                        for (int k = 0; k < 3; k++) begin
                            gsq_a_reg[k] <= SQW'(in_gabs[k]);
                            gsq_b_reg[k] <= in_gabs[k];
                            gsq_p_reg[k] <= '0;
                            gg_a_reg[k]  <= PW'(in_g[k]);
                            gg_b_reg[k]  <= gain_reg;
                            gg_p_reg[k]  <= '0;
                        end
                        cx_reg    <= ld_neg ? -ld_x : ld_x;
                        cy_reg    <= ld_neg ? -ld_y : ld_y;
                        cz_reg    <= ld_neg ? ica_pkg::HalfTurn : '0;
                        czero_reg <= (ld_y == '0);
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    for (int k = 0; k < 2; k++) begin
                        if (asq_b_reg[k][0]) asq_p_reg[k] <= asq_p_reg[k] + asq_a_reg[k];
                        asq_a_reg[k] <= asq_a_reg[k] << 1;
                        asq_b_reg[k] <= asq_b_reg[k] >> 1;
                    end
                    for (int k = 0; k < 3; k++) begin
                        if (gsq_b_reg[k][0]) gsq_p_reg[k] <= gsq_p_reg[k] + gsq_a_reg[k];
                        gsq_a_reg[k] <= gsq_a_reg[k] << 1;
                        gsq_b_reg[k] <= gsq_b_reg[k] >> 1;
                        if (gg_b_reg[k][0]) gg_p_reg[k] <= gg_p_reg[k] + gg_a_reg[k];
                        gg_a_reg[k] <= gg_a_reg[k] <<< 1;
                        gg_b_reg[k] <= gg_b_reg[k] >> 1;
                    end
                    if (cnt_reg != CordicLast && !czero_reg) begin
                        if (!cy_reg[CW-1]) begin
                            cx_reg <= cx_reg + cys;
                            cy_reg <= cy_reg - cxs;
                            cz_reg <= cz_reg + at_step;
                        end else begin
                            cx_reg <= cx_reg - cys;
                            cy_reg <= cy_reg + cxs;
                            cz_reg <= cz_reg - at_step;
                        end
                    end
                    if (cnt_reg == CordicLast) begin
                        // roll from the accel is ready: start the roll blend
                        pred_reg   <= roll_reg + delta[0];
                        bm_a_reg   <= BW'($signed(c_angle - (roll_reg + delta[0])));
                        bm_b_reg   <= 17'h10000 - {1'b0, alpha_reg};
                        bm_p_reg   <= '0;
                        sq_v_reg   <= VW'({asq_sum, 14'b0});
                        sq_rem_reg <= '0;
                        sq_r_reg   <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= S_SQRT;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_SQRT: begin
                    if (bm_b_reg[0]) bm_p_reg <= bm_p_reg + bm_a_reg;
                    bm_a_reg <= bm_a_reg <<< 1;
                    bm_b_reg <= bm_b_reg >> 1;
                    if (cnt_reg != SqrtLast) begin
                        cnt_reg    <= cnt_reg + 5'd1;
                        sq_v_reg   <= sq_v_reg << 2;
                        sq_rem_reg <= ge ? (REMW-2)'(rem_sh - trial) : (REMW-2)'(rem_sh);
                        sq_r_reg   <= {sq_r_reg[RW-2:0], ge};
                    end else begin
                        roll_reg  <= pred_reg + corr;
                        pred_reg  <= pitch_reg + delta[1];
                        moved_reg <= above;
                        if (above) yaw_reg <= yaw_reg + delta[2];
                        cx_reg    <= ld_neg ? -ld_x : ld_x;
                        cy_reg    <= ld_neg ? -ld_y : ld_y;
                        cz_reg    <= ld_neg ? ica_pkg::HalfTurn : '0;
                        czero_reg <= (ld_y == '0);
                        cnt_reg   <= '0;
                        state_reg <= S_PITCH;
                    end
                end
                S_PITCH: begin
                    if (cnt_reg != CordicLast && !czero_reg) begin
                        if (!cy_reg[CW-1]) begin
                            cx_reg <= cx_reg + cys;
                            cy_reg <= cy_reg - cxs;
                            cz_reg <= cz_reg + at_step;
                        end else begin
                            cx_reg <= cx_reg - cys;
                            cy_reg <= cy_reg + cxs;
                            cz_reg <= cz_reg - at_step;
                        end
                    end
                    if (cnt_reg == CordicLast) begin
                        bm_a_reg  <= BW'($signed(diff));
                        bm_b_reg  <= 17'h10000 - {1'b0, alpha_reg};
                        bm_p_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_PBLEND;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_PBLEND: begin
                    if (cnt_reg != BlendLast) begin
                        cnt_reg <= cnt_reg + 5'd1;
                        if (bm_b_reg[0]) bm_p_reg <= bm_p_reg + bm_a_reg;
                        bm_a_reg <= bm_a_reg <<< 1;
                        bm_b_reg <= bm_b_reg >> 1;
                    end else begin
                        pitch_reg <= pred_reg + corr;
                        cnt_reg   <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= OUTW'({moved_reg, yaw_reg, pitch_reg, roll_reg});
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a word is in work");

    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=>
        (state_reg == S_OUT && roll_reg == '0 && pitch_reg == '0 && yaw_reg == '0))
        else $error("clear word did not zero the angles");

    a_zero_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_MUL || state_reg == S_PITCH) && czero_reg) |=> $stable(cz_reg))
        else $error("cordic angle moved on a zero numerator");
`endif

endmodule

FILE: verif/tb_imu_complementary_attitude_filter.sv
// self-checking testbench for the imu complementary attitude filter
module tb_imu_complementary_attitude_filter;

    localparam int SW = 16;
    localparam int AW = 24;
    localparam int WatchdogLimit = 20000;
    // an index that maps to no register
    localparam logic [1:0] RegUnused = 2'd3;

    typedef struct packed {
        logic mode;
        logic [SW-1:0] ax, ay, az, gx, gy, gz;
    } sample_t;

    typedef struct packed {
        logic [AW-1:0] roll, pitch, yaw;
        logic moved;
    } attitude_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    logic s_tuser = 1'b0;       // mode
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [79:0] m_tdata;       // roll_angle, pitch_angle, yaw_angle, yaw_moved
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = ica_pkg::RegAlpha;
    logic [ica_pkg::CfgW-1:0] cfg_wdata = '0;
    logic s_taken = 1'b0;

    imu_complementary_attitude_filter u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // predictor state and registers
    logic [AW-1:0] roll_st, pitch_st, yaw_st;
    logic [15:0] alpha_r, ggain_r;
    logic [31:0] dband_r;

    sample_t pending_samples[$];
    attitude_t expected_attitude[$];
    int failures = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;

    function automatic logic [AW-1:0] atan2_angle(longint y, longint x);
        logic [31:0] z;
        longint xs, ys;
        z = 32'd0;
        if (y == 0) begin
            z = (x < 0) ? ica_pkg::HalfTurn : 32'd0;
        end else begin
            x = x * 256;
            y = y * 256;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = ica_pkg::HalfTurn;
            end
            for (int i = 0; i < ica_pkg::CordicSteps; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x += ys; y -= xs; z += ica_pkg::AtanTurn[i];
                end else begin
                    x -= ys; y += xs; z -= ica_pkg::AtanTurn[i];
                end
            end
        end
        return AW'(({32'd0, z} + 64'd128) >> 8);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint rate_step(longint g);
        return (g * longint'(ggain_r) + 128) >>> 8;
    endfunction

    function automatic logic [AW-1:0] fuse(logic [AW-1:0] prev, longint delta,
                                          logic [AW-1:0] acc_ang);
        logic [AW-1:0] pred, d;
        longint corr;
        pred = prev + AW'(delta);
        d = acc_ang - pred;
        corr = (longint'($signed(d)) * (65536 - longint'(alpha_r)) + 32768) >>> 16;
        return pred + AW'(corr);
    endfunction

    function automatic attitude_t update_attitude(sample_t s);
        attitude_t a;
        longint nx, ny, nz, gx, gy, gz;
        longint unsigned mag, r;
        a.moved = 1'b0;
        if (s.mode) begin
            roll_st = '0; pitch_st = '0; yaw_st = '0;
        end else begin
            nx = longint'($signed(s.ax)) * 256;
            ny = longint'($signed(s.ay)) * 256;
            nz = longint'($signed(s.az)) * 256;
            gx = longint'($signed(s.gx));
            gy = longint'($signed(s.gy));
            gz = longint'($signed(s.gz));
            r = int_sqrt(longint'(ny * ny + nz * nz) << 14);
            roll_st = fuse(roll_st, rate_step(gx), atan2_angle(ny, nz));
            pitch_st = fuse(pitch_st, rate_step(gy), atan2_angle(-nx * 128, longint'(r)));
            mag = gx * gx + gy * gy + gz * gz;
            if (mag > longint'(dband_r)) begin
                yaw_st = yaw_st + AW'(rate_step(gz));
                a.moved = 1'b1;
            end
        end
        a.roll = roll_st; a.pitch = pitch_st; a.yaw = yaw_st;
        return a;
    endfunction

    // remembers whether the word on the input was taken at the last edge
    always @(posedge aclk) begin
        s_taken <= s_tvalid && s_tready;
    end

    // driver
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !s_taken)) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_samples[0].mode;
                s_tdata <= {pending_samples[0].gz, pending_samples[0].gy,
                            pending_samples[0].gx, pending_samples[0].az,
                            pending_samples[0].ay, pending_samples[0].ax};
                void'(pending_samples.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge aclk) begin
        sample_t s;
        attitude_t got, want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (s_tvalid && s_tready) begin
                s = {s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
                     s_tdata[63:48], s_tdata[79:64], s_tdata[95:80]};
                expected_attitude.push_back(update_attitude(s));
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[23:0], m_tdata[47:24], m_tdata[71:48], m_tdata[72]};
                if (expected_attitude.size() == 0) begin
                    $error("result word with nothing expected");
                    failures++;
                end else begin
                    want = expected_attitude.pop_front();
                    if (got.roll !== want.roll) begin
                        $error("roll_angle expected %h got %h", want.roll, got.roll);
                        failures++;
                    end
                    if (got.pitch !== want.pitch) begin
                        $error("pitch_angle expected %h got %h", want.pitch, got.pitch);
                        failures++;
                    end
                    if (got.yaw !== want.yaw) begin
                        $error("yaw_angle expected %h got %h", want.yaw, got.yaw);
                        failures++;
                    end
                    if (got.moved !== want.moved) begin
                        $error("yaw_moved expected %b got %b", want.moved, got.moved);
                        failures++;
                    end
                end
            end
            if (idle_cycles >= WatchdogLimit) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            ica_pkg::RegAlpha: alpha_r = val[15:0];
            ica_pkg::RegGyro: ggain_r = val[15:0];
            ica_pkg::RegDeadband: dband_r = val;
            default: ;
        endcase
    endtask

    task automatic drain;
        while (pending_samples.size() > 0 || s_tvalid || expected_attitude.size() > 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    function automatic logic [SW-1:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(64)) - 32);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic sample_t rand_sample();
        sample_t s;
        s.mode = ($urandom_range(39) == 0);
        s.ax = rand_axis(); s.ay = rand_axis(); s.az = rand_axis();
        s.gx = rand_axis(); s.gy = rand_axis(); s.gz = rand_axis();
        // small rates probe the yaw threshold
        if ($urandom_range(3) == 0) begin
            s.gx = 16'(int'($urandom_range(200)) - 100);
            s.gy = 16'(int'($urandom_range(200)) - 100);
            s.gz = 16'(int'($urandom_range(200)) - 100);
        end
        return s;
    endfunction

    initial begin
        roll_st = '0; pitch_st = '0; yaw_st = '0;
        alpha_r = ica_pkg::AlphaReset;
        ggain_r = ica_pkg::GyroReset;
        dband_r = ica_pkg::DeadbandReset;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, zero numerators, clear, deadband edge
        pending_samples.push_back('{1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0});
        pending_samples.push_back('{1'b0, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0});
        pending_samples.push_back('{1'b0, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'd131});
        pending_samples.push_back('{1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'd132});
        pending_samples.push_back('{1'b0, 16'h7fff, 16'h7fff, 16'h7fff,
                                    16'h7fff, 16'h7fff, 16'h7fff});
        pending_samples.push_back('{1'b0, 16'h8000, 16'h8000, 16'h8000,
                                    16'h8000, 16'h8000, 16'h8000});
        pending_samples.push_back('{1'b0, 16'h8000, 16'h0, 16'h0, 16'h1, 16'hffff, 16'h8000});
        pending_samples.push_back('{1'b0, 16'h7fff, 16'hffff, 16'h0, 16'h0, 16'h0, 16'h7fff});
        pending_samples.push_back('{1'b1, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 16'h1, 16'h2});
        pending_samples.push_back('{1'b0, 16'h0, 16'h1, 16'hffff, 16'h0, 16'h0, 16'hffff});
        drain();

        write_reg(ica_pkg::RegAlpha, 32'd0);
        write_reg(ica_pkg::RegGyro, 32'hffff);
        write_reg(ica_pkg::RegDeadband, 32'hffff_ffff);
        write_reg(RegUnused, 32'h1234_5678);
        for (int i = 0; i < 8; i++) pending_samples.push_back(rand_sample());
        drain();
        write_reg(ica_pkg::RegAlpha, 32'hffff);
        write_reg(ica_pkg::RegGyro, 32'd0);
        write_reg(ica_pkg::RegDeadband, 32'd0);
        for (int i = 0; i < 6; i++) pending_samples.push_back(rand_sample());
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 51; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 51; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            write_reg(ica_pkg::RegAlpha, $urandom_range(65535));
            write_reg(ica_pkg::RegGyro, $urandom_range(3000));
            write_reg(ica_pkg::RegDeadband, $urandom_range(40000));
            for (int i = 0; i < 220; i++) pending_samples.push_back(rand_sample());
            drain();
        end

        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
